@@ hdl/cts_pkg.sv @@
package cts_pkg;

	// function codes carried in s_tuser
	localparam logic [1:0] FUNC_KEY  = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_LOAD = 2'd2;

	// key codes
	localparam logic [2:0] KEY_MODE   = 3'd1;
	localparam logic [2:0] KEY_SELECT = 3'd2;
	localparam logic [2:0] KEY_UP     = 3'd3;
	localparam logic [2:0] KEY_DOWN   = 3'd4;

	// field selector codes
	localparam logic [2:0] SEL_YEAR   = 3'd0;
	localparam logic [2:0] SEL_MONTH  = 3'd1;
	localparam logic [2:0] SEL_DAY    = 3'd2;
	localparam logic [2:0] SEL_HOUR   = 3'd3;
	localparam logic [2:0] SEL_MINUTE = 3'd4;
	localparam logic [2:0] SEL_SECOND = 3'd5;

	// register addresses on the apb port
	localparam logic [0:0] ADDR_BLINK_PERIOD = 1'b0;

	localparam logic [6:0] YEAR_MAX   = 7'd99;
	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;

	localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

	localparam logic [1:0] DAY_HI_MAX = 2'd2;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cts_time_t;

	// day_hi: 0 day below 32, 1 day in 32..63, 2 day 64 or more (only while month is 0)
	typedef struct packed {
		cts_time_t   tm;
		logic [1:0]  day_hi;
		logic [2:0]  sel;
		logic        edit;
		logic        blink;
		logic [15:0] tick;
	} cts_state_t;

	// days in month, 0 for a month outside 1..12
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		begin
			if (m == 4'd2) begin
				d = leap ? 5'd29 : 5'd28;
			end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
				d = 5'd30;
			end else if (m >= 4'd1 && m <= MONTH_MAX) begin
				d = 5'd31;
			end else begin
				d = 5'd0;
			end
			return d;
		end
	endfunction

endpackage

@@ hdl/cts_update.sv @@
module cts_update import cts_pkg::*; (
	input  cts_state_t  cur,
	input  logic [1:0]  func,
	input  logic [2:0]  key,
	input  cts_time_t   load_tm,
	input  logic [15:0] blink_period,
	output cts_state_t  nxt,
	output logic        commit
);

	logic       adj, down;
	logic       yr_sel, mo_sel, dy_sel, hr_sel, mi_sel, se_sel;
	logic [7:0] yr_sum;
	logic [6:0] yr_w;
	logic [4:0] mo_sum;
	logic       mo_below;
	logic [3:0] mo_w;
	logic [4:0] lim;
	logic [5:0] dy_inc;
	logic [4:0] dy_lo;
	logic [1:0] dy_hi;
	logic       dy_below;
	logic [4:0] dy_w;
	logic [1:0] dy_hi_w;
	logic [5:0] hr_sum;
	logic [4:0] hr_w;
	logic [6:0] mi_sum, se_sum;
	logic [5:0] mi_w, se_w;
	logic [16:0] tick_inc;
	cts_time_t  adj_tm;

	assign down   = (key == KEY_DOWN);
	assign yr_sel = (cur.sel == SEL_YEAR);
	assign mo_sel = (cur.sel == SEL_MONTH);
	assign dy_sel = (cur.sel == SEL_DAY);
	assign hr_sel = (cur.sel == SEL_HOUR);
	assign mi_sel = (cur.sel == SEL_MINUTE);
	assign se_sel = (cur.sel == SEL_SECOND);

	// year
	always_comb begin
		yr_sum = {1'b0, cur.tm.year};
		if (yr_sel) yr_sum = down ? yr_sum - 8'd1 : yr_sum + 8'd1;
		if (yr_sel && down && cur.tm.year == 7'd0) begin
			yr_w = YEAR_MAX;
		end else if (yr_sum > {1'b0, YEAR_MAX}) begin
			yr_w = 7'd0;
		end else begin
			yr_w = yr_sum[6:0];
		end
	end

	// month
	always_comb begin
		mo_sum = {1'b0, cur.tm.month};
		if (mo_sel) mo_sum = down ? mo_sum - 5'd1 : mo_sum + 5'd1;
		mo_below = down && (mo_sel ? (cur.tm.month <= 4'd1) : (cur.tm.month == 4'd0));
		if (mo_below) begin
			mo_w = MONTH_MAX;
		end else if (mo_sum > {1'b0, MONTH_MAX}) begin
			mo_w = 4'd1;
		end else begin
			mo_w = mo_sum[3:0];
		end
	end

	assign lim = month_days(mo_w, (yr_w[1:0] == 2'd0));

	// day, with the overflow count kept for a month of zero
	always_comb begin
		dy_inc   = {1'b0, cur.tm.day} + 6'd1;
		dy_lo    = cur.tm.day;
		dy_hi    = cur.day_hi;
		dy_below = 1'b0;
		if (dy_sel && !down) begin
			dy_lo = dy_inc[4:0];
			if (dy_inc[5]) dy_hi = (cur.day_hi == DAY_HI_MAX) ? DAY_HI_MAX : cur.day_hi + 2'd1;
		end else if (dy_sel && down) begin
			dy_lo = cur.tm.day - 5'd1;
			if (cur.day_hi == 2'd0) begin
				dy_below = (cur.tm.day <= 5'd1);
			end else if (cur.tm.day == 5'd0 && cur.day_hi == 2'd1) begin
				dy_hi = 2'd0;
			end
		end else begin
			dy_below = (cur.day_hi == 2'd0) && (cur.tm.day == 5'd0);
		end
		dy_w    = dy_lo;
		dy_hi_w = dy_hi;
		if (lim != 5'd0) begin
			if (down && dy_below) begin
				dy_w    = lim;
				dy_hi_w = 2'd0;
			end else if (dy_hi != 2'd0 || dy_lo > lim) begin
				dy_w    = 5'd1;
				dy_hi_w = 2'd0;
			end
		end
	end

	// hour, minute, second
	always_comb begin
		hr_sum = {1'b0, cur.tm.hour};
		if (hr_sel) hr_sum = down ? hr_sum - 6'd1 : hr_sum + 6'd1;
		if (hr_sel && down && cur.tm.hour == 5'd0) hr_w = HOUR_MAX;
		else if (hr_sum > {1'b0, HOUR_MAX}) hr_w = 5'd0;
		else hr_w = hr_sum[4:0];

		mi_sum = {1'b0, cur.tm.minute};
		if (mi_sel) mi_sum = down ? mi_sum - 7'd1 : mi_sum + 7'd1;
		if (mi_sel && down && cur.tm.minute == 6'd0) mi_w = MINSEC_MAX;
		else if (mi_sum > {1'b0, MINSEC_MAX}) mi_w = 6'd0;
		else mi_w = mi_sum[5:0];

		se_sum = {1'b0, cur.tm.second};
		if (se_sel) se_sum = down ? se_sum - 7'd1 : se_sum + 7'd1;
		if (se_sel && down && cur.tm.second == 6'd0) se_w = MINSEC_MAX;
		else if (se_sum > {1'b0, MINSEC_MAX}) se_w = 6'd0;
		else se_w = se_sum[5:0];
	end

	assign adj_tm   = '{year: yr_w, month: mo_w, day: dy_w, hour: hr_w, minute: mi_w,
		second: se_w};
	assign adj      = cur.edit && (key == KEY_UP || key == KEY_DOWN);
	assign tick_inc = {1'b0, cur.tick} + 17'd1;

	always_comb begin
		nxt    = cur;
		commit = 1'b0;
		unique case (func)
			FUNC_KEY: begin
				if (key == KEY_MODE) begin
					nxt.edit = !cur.edit;
					commit   = cur.edit;
				end else if (cur.edit && key == KEY_SELECT) begin
					nxt.sel = (cur.sel == SEL_SECOND) ? SEL_YEAR : cur.sel + 3'd1;
				end else if (adj) begin
					nxt.tm     = adj_tm;
					nxt.day_hi = dy_hi_w;
				end
			end
			FUNC_TICK: begin
				if (tick_inc >= {1'b0, blink_period}) begin
					nxt.tick  = 16'd0;
					nxt.blink = !cur.blink;
				end else begin
					nxt.tick = tick_inc[15:0];
				end
			end
			FUNC_LOAD: begin
				if (!cur.edit) begin
					nxt.tm     = load_tm;
					nxt.day_hi = 2'd0;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/clock_time_set_editor_unit.sv @@
// time-setting editor for a calendar clock
// input stream: one request per item; s_tuser selects key event, millisecond tick
// or load of the time read from the clock chip, s_tdata carries key and load time
// output stream: exactly one result per request with the time, selector, edit mode,
// blank flag for the selected field and a one-result commit pulse on leaving edit
// apb port: one register, blink_period at address 0, ticks between blink toggles
// a request passes the input register, then the result register behind m_tvalid
// throughput: one request per cycle unless m_tready stalls; the state update is a
// single pass of compare-and-wrap logic between the input register and the result register
// stalls: a held result keeps the input register loaded and s_tready low only
// when both stages are full, so the pipeline keeps streaming while m_tready is high
// reset: time goes to year 0, month 1, day 1, 00:00:00, display mode, selector on
// year, blink off, tick count 0, blink_period 500; no request is in flight
module clock_time_set_editor_unit import cts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // key[2:0], new_year[9:3], new_month[13:10],
	                              // new_day[18:14], new_hour[23:19], new_minute[29:24],
	                              // new_second[35:30], zero fill
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // year[6:0], month[10:7], day[15:11], hour[20:16],
	                              // minute[26:21], second[32:27], selected_field[35:33],
	                              // editing[36], blank_selected[37], commit[38], zero fill
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [2:0]  key_s1;
	cts_time_t   load_s1;
	logic        advance;
	cts_state_t  state_q, state_nxt;
	logic        commit_nxt;
	logic [15:0] blink_period_q;
	logic        out_valid_q;
	logic [39:0] out_data_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BLINK_PERIOD) ? {16'd0, blink_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= BLINK_PERIOD_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_BLINK_PERIOD) begin
			blink_period_q <= pwdata[15:0];
		end
	end

	// stage 1 advances whenever the result register is free or being emptied
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_tuser;
			key_s1  <= s_tdata[2:0];
			load_s1 <= '{year: s_tdata[9:3], month: s_tdata[13:10], day: s_tdata[18:14],
				hour: s_tdata[23:19], minute: s_tdata[29:24], second: s_tdata[35:30]};
		end
	end

	cts_update u_update (
		.cur          (state_q),
		.func         (func_s1),
		.key          (key_s1),
		.load_tm      (load_s1),
		.blink_period (blink_period_q),
		.nxt          (state_nxt),
		.commit       (commit_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{tm: '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
				minute: 6'd0, second: 6'd0}, day_hi: 2'd0, sel: SEL_YEAR, edit: 1'b0,
				blink: 1'b0, tick: 16'd0};
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {1'b0, commit_nxt, state_nxt.edit && state_nxt.blink,
				state_nxt.edit, state_nxt.sel, state_nxt.tm.second, state_nxt.tm.minute,
				state_nxt.tm.hour, state_nxt.tm.day, state_nxt.tm.month, state_nxt.tm.year};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a commit always leaves the block in display mode
	a_commit_display: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38] |-> !m_tdata[36])
		else $error("commit shown while still editing");

	a_blank_edit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[37] |-> m_tdata[36])
		else $error("blank selected outside edit mode");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sel <= SEL_SECOND)
		else $error("selector out of range");

	// day overflow past 31 only builds up while the month is zero
	a_day_hi_month: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.day_hi != 2'd0 |-> state_q.tm.month == 4'd0)
		else $error("day overflow with a valid month");

endmodule
